// ===== src/mbp_pkg.sv =====
// shared types, constants and the status length decode of the midi parser
package mbp_pkg;

  localparam int SYSEX_MAX_BYTES = 8192;
  localparam int SX_COUNT_W = $clog2(SYSEX_MAX_BYTES);
  localparam logic [SX_COUNT_W-1:0] SX_LIMIT = SX_COUNT_W'(SYSEX_MAX_BYTES - 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] STATUS_SYSEX = 8'hF0;
  localparam logic [7:0] STATUS_EOX = 8'hF7;
  localparam logic [7:0] REALTIME_FIRST = 8'hF8;

  localparam logic KIND_SHORT = 1'b0;
  localparam logic KIND_SYSEX = 1'b1;

  // lengths of the system statuses f0..ff
  localparam logic [1:0] SYS_LEN [16] = '{
    2'd0, 2'd2, 2'd3, 2'd2, 2'd0, 2'd0, 2'd1, 2'd0,
    2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd0
  };

  typedef struct packed {
    logic        out_kind;
    logic [23:0] msg_word;
    logic [1:0]  msg_len;
    logic [7:0]  sysex_data;
    logic        sysex_end;
    logic        last;
  } result_t;

  // results caused by one byte, one or two of them
  typedef struct packed {
    result_t res0;
    result_t res1;
    logic    two;
  } rec_t;

  typedef struct packed {
    logic valid;
    rec_t rec;
  } push_t;

  function automatic logic [1:0] status_length(input logic [7:0] s);
    logic [1:0] len;
    unique case (s[7:4]) inside
      [4'h8:4'hB]: len = 2'd3;
      4'hC, 4'hD:  len = 2'd2;
      4'hE:        len = 2'd3;
      4'hF:        len = SYS_LEN[s[3:0]];
      default:     len = 2'd0;
    endcase
    return len;
  endfunction

  function automatic result_t short_msg(input logic [23:0] word, input logic [1:0] len);
    result_t r;
    r = '0;
    r.out_kind = KIND_SHORT;
    r.msg_word = word;
    r.msg_len = len;
    return r;
  endfunction

  function automatic result_t sysex_byte(input logic [7:0] b, input logic is_end);
    result_t r;
    r = '0;
    r.out_kind = KIND_SYSEX;
    r.sysex_data = b;
    r.sysex_end = is_end;
    return r;
  endfunction

endpackage

// ===== src/mbp_byte_if.sv =====
// request channel carrying raw midi bytes
interface mbp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// ===== src/mbp_result_if.sv =====
// request channel carrying parsed midi results
interface mbp_result_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [23:0] msg_word;
  logic [1:0]  msg_len;
  logic [7:0]  sysex_data;
  logic        sysex_end;
  logic        last;

  modport source (output valid, output out_kind, output msg_word, output msg_len,
                  output sysex_data, output sysex_end, output last, input ready);
  modport sink (input valid, input out_kind, input msg_word, input msg_len,
                input sysex_data, input sysex_end, input last, output ready);
endinterface

// ===== src/midi_byte_stream_parser.sv =====
// top level of the midi byte stream parser with running status
//
// midi: one raw midi byte per request, valid/ready handshake
// result: one parsed item per request; out_kind 0 is a packed short message
//   (msg_word, msg_len), out_kind 1 a single sysex byte (sysex_data, sysex_end);
//   last marks the final item caused by one input byte
// a byte may cause no item, one, or two (a sysex closed by a new status gives
//   the added f7 and then whatever the new status starts)
// path: an item passes from the front end into the record queue and then
//   into the output register before it leaves
// throughput: one byte per cycle while each causes at most one item and the
//   receiver keeps up; the output register sends one item per cycle, so a byte
//   with two items uses it twice, absorbed by the two-entry record queue
// reset: running status, message length, position and sysex count clear,
//   the queue and output register empty
// when the receiver stalls the output holds, the queue fills and midi.ready
//   drops only once both queue entries are in use
module midi_byte_stream_parser (
  input  logic         clk,
  input  logic         rst,
  mbp_byte_if.sink     midi,
  mbp_result_if.source result
);
  import mbp_pkg::*;

  push_t push;
  logic  q_ready;
  logic  q_valid;
  rec_t  q_rec;
  logic  pop;

  // classify each byte and update the parser state
  mbp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .midi    (midi),
    .q_ready (q_ready),
    .push    (push)
  );

  // decouples the parser from output stalls
  mbp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .ready   (q_ready),
    .q_valid (q_valid),
    .q_rec   (q_rec),
    .pop     (pop)
  );

  // one result per cycle out of each record while the receiver is ready
  mbp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_rec   (q_rec),
    .pop     (pop),
    .result  (result)
  );

endmodule

// ===== src/mbp_front.sv =====
// front end: takes bytes, tracks running status and builds result records
module mbp_front (
  input  logic            clk,
  input  logic            rst,
  mbp_byte_if.sink        midi,
  input  logic            q_ready,
  output mbp_pkg::push_t  push
);
  import mbp_pkg::*;

  logic [7:0]            running_status, running_status_next;
  logic [1:0]            expected_length, expected_length_next;
  logic [1:0]            byte_position, byte_position_next;
  logic [7:0]            message_bytes [3];
  logic [7:0]            message_bytes_next [3];
  logic [SX_COUNT_W-1:0] sysex_count, sysex_count_next;

  logic       accept;
  logic [1:0] n;
  result_t    r0, r1;
  logic [23:0] word;
  logic [7:0] b;
  logic       proceed;

  assign midi.ready = q_ready;
  assign accept = midi.valid && q_ready;
  assign b = midi.in_byte;

  always_comb begin
    running_status_next = running_status;
    expected_length_next = expected_length;
    byte_position_next = byte_position;
    message_bytes_next = message_bytes;
    sysex_count_next = sysex_count;
    n = 2'd0;
    r0 = '0;
    r1 = '0;
    word = '0;
    proceed = 1'b1;

    if (b >= REALTIME_FIRST) begin
      // real-time byte goes out alone, state untouched
      r0 = short_msg({16'h0, b}, 2'd1);
      n = 2'd1;
    end else begin
      if (running_status == STATUS_SYSEX) begin
        if (!b[7]) begin
          proceed = 1'b0;
          if (sysex_count < SX_LIMIT) begin
            sysex_count_next = sysex_count + 1'b1;
            r0 = sysex_byte(b, 1'b0);
            n = 2'd1;
          end
        end else begin
          // any status closes the sysex
          r0 = sysex_byte(STATUS_EOX, 1'b1);
          n = 2'd1;
          sysex_count_next = '0;
        end
      end

      if (proceed) begin
        if (b[7]) begin
          running_status_next = b;
          byte_position_next = 2'd0;
          expected_length_next = status_length(b);
          message_bytes_next = '{default: 8'h00};
          if (b == STATUS_SYSEX) begin
            sysex_count_next = SX_COUNT_W'(1);
            if (n == 2'd0) begin
              r0 = sysex_byte(STATUS_SYSEX, 1'b0);
              n = 2'd1;
            end else begin
              r1 = sysex_byte(STATUS_SYSEX, 1'b0);
              n = 2'd2;
            end
          end
        end

        if (expected_length_next != 2'd0) begin
          if (byte_position_next != 2'd3) begin
            message_bytes_next[byte_position_next] = b;
          end
          byte_position_next = byte_position_next + 2'd1;
          if (byte_position_next >= expected_length_next) begin
            for (int i = 0; i < 3; i++) begin
              if (2'(i) < expected_length_next) begin
                word[8*i +: 8] = message_bytes_next[i];
              end
            end
            if (n == 2'd0) begin
              r0 = short_msg(word, expected_length_next);
              n = 2'd1;
            end else begin
              r1 = short_msg(word, expected_length_next);
              n = 2'd2;
            end
            if (running_status_next >= STATUS_SYSEX) begin
              // system common cancels running status
              running_status_next = '0;
              expected_length_next = 2'd0;
              byte_position_next = 2'd0;
            end else begin
              byte_position_next = 2'd1;
            end
          end
        end
      end
    end

    if (n == 2'd2) begin
      r1.last = 1'b1;
    end else begin
      r0.last = 1'b1;
    end
  end

  always_comb begin
    push.valid = accept && (n != 2'd0);
    push.rec.res0 = r0;
    push.rec.res1 = r1;
    push.rec.two = (n == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_status <= '0;
      expected_length <= '0;
      byte_position <= '0;
      message_bytes <= '{default: 8'h00};
      sysex_count <= '0;
    end else if (accept) begin
      running_status <= running_status_next;
      expected_length <= expected_length_next;
      byte_position <= byte_position_next;
      message_bytes <= message_bytes_next;
      sysex_count <= sysex_count_next;
    end
  end

endmodule

// ===== src/mbp_queue.sv =====
// short record queue between front and back end
module mbp_queue (
  input  logic            clk,
  input  logic            rst,
  input  mbp_pkg::push_t  push,
  output logic            ready,
  output logic            q_valid,
  output mbp_pkg::rec_t   q_rec,
  input  logic            pop
);
  import mbp_pkg::*;

  rec_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_rec = entries[rd_ptr];
  assign do_push = push.valid && ready;
  assign do_pop = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/mbp_back.sv =====
// back end: splits records into single results behind an output register
module mbp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  mbp_pkg::rec_t   q_rec,
  output logic            pop,
  mbp_result_if.source    result
);
  import mbp_pkg::*;

  logic    out_valid;
  result_t out_res;
  logic    pend_valid;
  result_t pend_res;
  logic    can_load;

  assign can_load = !out_valid || result.ready;
  assign pop = can_load && !pend_valid && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else if (can_load) begin
      if (pend_valid) begin
        out_valid <= 1'b1;
        pend_valid <= 1'b0;
      end else if (q_valid) begin
        out_valid <= 1'b1;
        pend_valid <= q_rec.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_load) begin
      if (pend_valid) begin
        out_res <= pend_res;
      end else if (q_valid) begin
        out_res <= q_rec.res0;
        pend_res <= q_rec.res1;
      end
    end
  end

  assign result.valid = out_valid;
  assign result.out_kind = out_res.out_kind;
  assign result.msg_word = out_res.msg_word;
  assign result.msg_len = out_res.msg_len;
  assign result.sysex_data = out_res.sysex_data;
  assign result.sysex_end = out_res.sysex_end;
  assign result.last = out_res.last;

endmodule

// ===== bench/mbp_checker.sv =====
// scoreboard for the midi parser: predicts the items of each accepted byte and checks them in order
`timescale 1ns / 1ps
module mbp_checker (
  input  logic  clk,
  input  logic  rst,
  mbp_byte_if   midi,
  mbp_result_if result,
  output int    failures,
  output int    pending
);
  import mbp_pkg::*;

  localparam logic [13:0] SYSEX_CAP = 14'(SYSEX_MAX_BYTES - 1);
  localparam int REPORT_LIMIT = 200;

  logic [7:0]  cur_status;
  logic [1:0]  msg_length;
  logic [1:0]  msg_pos;
  logic [7:0]  msg_bytes [3];
  logic [13:0] sysex_sent;
  result_t     awaited_results [$];
  int          reported;

  function automatic logic [1:0] message_length(input logic [7:0] s);
    logic [1:0] len;
    len = 2'd0;
    case (s[7:4])
      4'h8, 4'h9, 4'hA, 4'hB, 4'hE: len = 2'd3;
      4'hC, 4'hD: len = 2'd2;
      4'hF: begin
        case (s[3:0])
          4'h2: len = 2'd3;
          4'h1, 4'h3: len = 2'd2;
          4'h6, 4'h8, 4'hA, 4'hB, 4'hC, 4'hE: len = 2'd1;
          default: len = 2'd0;
        endcase
      end
      default: len = 2'd0;
    endcase
    return len;
  endfunction

  task automatic parse_byte(input logic [7:0] b);
    result_t     res [2];
    int          n;
    int          i;
    logic [23:0] word;
    n = 0;
    res[0] = '0;
    res[1] = '0;
    if (b >= REALTIME_FIRST) begin
      // real-time goes straight out, state untouched
      res[0] = '{out_kind: KIND_SHORT, msg_word: {16'h0, b}, msg_len: 2'd1, default: '0};
      n = 1;
    end else if (cur_status == STATUS_SYSEX && !b[7]) begin
      // data past the cap is dropped silently
      if (sysex_sent < SYSEX_CAP) begin
        sysex_sent = sysex_sent + 14'd1;
        res[0] = '{out_kind: KIND_SYSEX, sysex_data: b, default: '0};
        n = 1;
      end
    end else begin
      if (cur_status == STATUS_SYSEX) begin
        res[0] = '{out_kind: KIND_SYSEX, sysex_data: STATUS_EOX, sysex_end: 1'b1, default: '0};
        n = 1;
        sysex_sent = '0;
      end
      if (b[7]) begin
        cur_status = b;
        msg_pos = '0;
        msg_length = message_length(b);
        msg_bytes = '{default: '0};
        if (b == STATUS_SYSEX) begin
          sysex_sent = 14'd1;
          res[n] = '{out_kind: KIND_SYSEX, sysex_data: STATUS_SYSEX, default: '0};
          n++;
        end
      end
      if (msg_length != 2'd0) begin
        if (msg_pos != 2'd3) msg_bytes[msg_pos] = b;
        msg_pos = msg_pos + 2'd1;
        if (msg_pos >= msg_length) begin
          word = '0;
          for (i = 0; i < 3; i++)
            if (i < msg_length) word[8*i +: 8] = msg_bytes[i];
          res[n] = '{out_kind: KIND_SHORT, msg_word: word, msg_len: msg_length, default: '0};
          n++;
          // system common ends running status, channel messages keep it
          if (cur_status >= STATUS_SYSEX) begin
            cur_status = '0;
            msg_length = '0;
            msg_pos = '0;
          end else begin
            msg_pos = 2'd1;
          end
        end
      end
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (i = 0; i < n; i++) awaited_results = {awaited_results, res[i]};
  endtask

  task automatic report(input string what);
    failures++;
    if (reported < REPORT_LIMIT) $display("%0t ns: %s", $time, what);
    else if (reported == REPORT_LIMIT) $display("%0t ns: further mismatches not shown", $time);
    reported++;
  endtask

  task automatic compare_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
    if (got !== want) report($sformatf("%s expected %0h actual %0h", name, want, got));
  endtask

  task automatic check_result();
    result_t got;
    result_t want;
    got = {result.out_kind, result.msg_word, result.msg_len, result.sysex_data,
           result.sysex_end, result.last};
    if (awaited_results.size() == 0) begin
      report($sformatf({"expected no item, actual kind %0h word %06h len %0h",
                        " sysex %02h end %0h last %0h"},
                       got.out_kind, got.msg_word, got.msg_len, got.sysex_data,
                       got.sysex_end, got.last));
    end else begin
      want = awaited_results.pop_front();
      compare_field("out_kind", 24'(want.out_kind), 24'(got.out_kind));
      compare_field("msg_word", want.msg_word, got.msg_word);
      compare_field("msg_len", 24'(want.msg_len), 24'(got.msg_len));
      compare_field("sysex_data", 24'(want.sysex_data), 24'(got.sysex_data));
      compare_field("sysex_end", 24'(want.sysex_end), 24'(got.sysex_end));
      compare_field("last", 24'(want.last), 24'(got.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cur_status = '0;
      msg_length = '0;
      msg_pos = '0;
      msg_bytes = '{default: '0};
      sysex_sent = '0;
      awaited_results.delete();
    end else begin
      if (midi.valid && midi.ready) parse_byte(midi.in_byte);
      if (result.valid && result.ready) check_result();
    end
    pending = awaited_results.size();
  end

endmodule

// ===== bench/tb_midi_byte_stream_parser.sv =====
// stimulus, flow control and verdict for the midi byte stream parser
`timescale 1ns / 1ps
module tb_midi_byte_stream_parser;
  import mbp_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_BYTES  = 1800;
  // data bytes of the long directed sysex
  localparam int SYSEX_RUN     = 64;
  localparam int LONG_HOLD     = 300;
  // results pass only the record queue and the output register after their byte, so this is plenty
  localparam int SETTLE_CYCLES = 10;

  // status bytes used by name in the stimulus
  localparam logic [7:0] ST_NOTE_ON  = 8'h90;
  localparam logic [7:0] ST_PROG     = 8'hC0;
  localparam logic [7:0] ST_CHAN_AT  = 8'hD0;
  localparam logic [7:0] ST_MTC      = 8'hF1;
  localparam logic [7:0] ST_SONG_POS = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL = 8'hF3;
  localparam logic [7:0] ST_UNDEF_F4 = 8'hF4;
  localparam logic [7:0] ST_UNDEF_F5 = 8'hF5;
  localparam logic [7:0] ST_TUNE     = 8'hF6;
  localparam logic [7:0] RT_ACTIVE   = 8'hFE;
  localparam logic [7:0] RT_RESET    = 8'hFF;

  // every status of the system common group, the odd ones included
  localparam logic [7:0] SYSTEM_STATUS [7] = '{
    ST_MTC, ST_SONG_POS, ST_SONG_SEL, ST_UNDEF_F4, ST_UNDEF_F5, ST_TUNE, STATUS_EOX
  };

  // opening sequence, grouped by the behaviour it aims at
  localparam logic [7:0] OPENING [32] = '{
    8'h00, RT_RESET,                          // stray data before any status, real-time
    ST_NOTE_ON, 8'h3C, REALTIME_FIRST, 8'h7F, // clock byte in the middle of a note on
    8'h3C, 8'h00,                             // running status
    ST_PROG | 8'h0F, 8'h7F,                   // two byte message, top channel
    STATUS_EOX, 8'h11,                        // end of exclusive with no sysex open
    ST_UNDEF_F4, 8'h22, ST_UNDEF_F5,          // undefined statuses swallow data
    ST_SONG_POS, 8'h01, 8'h02, 8'h33,         // common message cancels running status
    ST_TUNE,                                  // one byte common message
    STATUS_SYSEX, 8'h7F, RT_ACTIVE, 8'h00, STATUS_EOX, // sysex with real-time inside
    STATUS_SYSEX, 8'h45, STATUS_SYSEX,        // sysex closed by a new sysex
    ST_MTC, 8'h05,                            // sysex closed by a common status
    STATUS_SYSEX, ST_TUNE                     // closing f7 plus a complete message
  };

  logic clk;
  logic rst;
  int   failures;
  int   pending;
  int   bytes_taken;
  int   bytes_sent;
  bit   calm;         // no idling on either side while set
  bit   hold_wanted;  // stimulus asks the receiver for a long hold-off
  bit   hold_active;  // receiver is in that hold-off

  mbp_byte_if   midi_ch ();
  mbp_result_if result_ch ();

  midi_byte_stream_parser u_top (
    .clk    (clk),
    .rst    (rst),
    .midi   (midi_ch),
    .result (result_ch)
  );

  mbp_checker u_check (
    .clk      (clk),
    .rst      (rst),
    .midi     (midi_ch),
    .result   (result_ch),
    .failures (failures),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // a request is taken at a rising edge with valid and ready both high
  always @(posedge clk) begin
    if (midi_ch.valid && midi_ch.ready) bytes_taken <= bytes_taken + 1;
  end

  // idle length: mostly none or short, now and then a long one
  function automatic int idle_cycles();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one byte at the falling edge and hold it until the request is taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    int seen;
    gap = idle_cycles();
    if (gap > 0) begin
      midi_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    seen = bytes_taken;
    midi_ch.valid <= 1'b1;
    midi_ch.in_byte <= b;
    @(negedge clk);
    while (bytes_taken == seen) @(negedge clk);
    bytes_sent++;
  endtask

  // random data byte, sometimes preceded by a real-time byte slipped in
  task automatic send_data();
    if ($urandom_range(0, 99) < 4) send_byte(REALTIME_FIRST | 8'($urandom_range(0, 7)));
    send_byte(8'($urandom_range(0, 127)));
  endtask

  // mostly well-formed messages with random content, the rest noise
  task automatic send_random_sequence();
    int         roll;
    int         per_msg;
    logic [7:0] st;
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      // channel message, often repeated under running status
      st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom_range(0, 15))};
      per_msg = (st[7:4] == ST_PROG[7:4] || st[7:4] == ST_CHAN_AT[7:4]) ? 1 : 2;
      send_byte(st);
      repeat ($urandom_range(1, 4)) begin
        repeat (per_msg) send_data();
      end
      // now and then a message left half done, cut off by whatever follows
      if (per_msg == 2 && $urandom_range(0, 9) == 0) send_data();
    end else if (roll < 55) begin
      // system common, with data after it that completes the message or is ignored
      send_byte(SYSTEM_STATUS[$urandom_range(0, 6)]);
      repeat ($urandom_range(0, 3)) send_data();
    end else if (roll < 72) begin
      // sysex, mostly closed properly, otherwise ended by the next status
      send_byte(STATUS_SYSEX);
      repeat ($urandom_range(0, 24)) send_data();
      if ($urandom_range(0, 99) < 65) send_byte(STATUS_EOX);
    end else if (roll < 80) begin
      send_byte(REALTIME_FIRST | 8'($urandom_range(0, 7)));
    end else begin
      // raw noise covers every bit pattern of the byte
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end
  endtask

  // sender pauses until every awaited item has come back
  task automatic drain();
    midi_ch.valid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    @(negedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request so the
  // parser's queue fills and it drops midi ready
  initial begin : receiver
    int stall;
    result_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_wanted) begin
        result_ch.ready <= 1'b0;
        hold_active = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_active = 1'b0;
      end else begin
        stall = idle_cycles();
        if (stall > 0) begin
          result_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int random_start;
    rst = 1'b1;
    midi_ch.valid = 1'b0;
    midi_ch.in_byte = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // directed opening, with idling on both sides
    for (int i = 0; i < $size(OPENING); i++) send_byte(OPENING[i]);
    drain();

    // long sysex; a real-time byte still gets through and a new status
    // closes it before a note on
    calm = 1'b1;
    send_byte(STATUS_SYSEX);
    repeat (SYSEX_RUN) send_byte(8'($urandom_range(0, 127)));
    send_byte(RT_ACTIVE);
    send_byte(8'h7F);
    send_byte(ST_NOTE_ON);
    send_byte(8'h40);
    send_byte(8'h00);
    drain();

    // random traffic in four phases: idling, calm, calm behind a long
    // receiver hold-off, idling again; each phase drains before the next
    random_start = bytes_sent;
    for (int phase = 0; phase < 4; phase++) begin
      calm = (phase == 1 || phase == 2);
      if (phase == 2) begin
        hold_wanted = 1'b1;
        wait (hold_active);
        hold_wanted = 1'b0;
      end
      while (bytes_sent < random_start + (phase + 1) * RANDOM_BYTES / 4)
        send_random_sequence();
      drain();
    end

    // let any stray item show up before the verdict
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // hard stop, several times the slowest legal run
  initial begin : watchdog
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
